// File: rtl/core/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types, widths and codes for the positional list block.
// ----------------------------------------------------------------------------
package plist_pkg;

	localparam int LIST_DEPTH = 16;

	localparam int VAL_W = 31;
	localparam int POS_W = 5;
	localparam int OUT_CNT_W = 5;
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_FIND   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_POS  = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NO_MATCH = 2'd3
	} status_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;  // open a slot at pos and write value
		logic del;  // close the slot at pos
		logic cap;  // capture the compare result
	} cell_ctl_t;

	// Truncate a count to the width of the result field
	function automatic logic [OUT_CNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] cnt);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(cnt);
		return wide[OUT_CNT_W-1:0];
	endfunction

endpackage

// File: rtl/core/plist_cell.sv
// ----------------------------------------------------------------------------
// plist_cell
// One list slot: holds an entry, shifts from a neighbor, compares to a key.
// ----------------------------------------------------------------------------
module plist_cell (
	input  logic                                 clk,
	input  logic [plist_pkg::IDX_W-1:0]          idx,
	input  plist_pkg::cell_ctl_t                 ctl,
	input  logic [plist_pkg::POS_W-1:0]          pos,
	input  logic signed [plist_pkg::VAL_W-1:0]   value,
	input  logic [plist_pkg::CNT_W-1:0]          count,
	input  logic signed [plist_pkg::VAL_W-1:0]   left_entry,
	input  logic signed [plist_pkg::VAL_W-1:0]   right_entry,
	output logic signed [plist_pkg::VAL_W-1:0]   entry,
	output logic signed [plist_pkg::VAL_W-1:0]   sel_entry,
	output logic                                 match
);
	import plist_pkg::*;

	logic signed [VAL_W-1:0] entry_q;
	logic                    match_q;
	logic [CMP_W-1:0]        slot_pos;
	logic [CMP_W-1:0]        req_pos;

	assign slot_pos = CMP_W'(idx) + CMP_W'(1);
	assign req_pos  = CMP_W'(pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (slot_pos > req_pos) begin
				entry_q <= left_entry;
			end else if (slot_pos == req_pos) begin
				entry_q <= value;
			end
		end else if (ctl.del && slot_pos >= req_pos) begin
			entry_q <= right_entry;
		end
	end

	// Only live slots may report a hit
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			match_q <= (entry_q == value) && (CMP_W'(idx) < CMP_W'(count));
		end
	end

	assign entry     = entry_q;
	assign sel_entry = (slot_pos == req_pos) ? entry_q : '0;
	assign match     = match_q;

endmodule

// File: rtl/core/positional_list_insert_delete_find.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_find
// Ordered list of signed values kept in a chain of slots, with positional
// insert and delete, search by value and clear.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-----------------------------------
//  in      | sink      | in_valid/in_stall  | mode, position, value
//  out     | source    | out_valid/out_stall| status, removed_value,
//          |           |                    | found_position, entry_count
//
// Each command goes through accept, execute (all slots shift or compare in
// parallel) and finish (priority pick of the first hit, load of the output
// register). A new command is taken in the cycle after the previous one is
// finished, so the block works on only one command at a time.
// Reset clears the count and the handshake state; slot contents are not
// cleared, and slots beyond the count are never read.
// out_stall only holds the output register; a finished result waiting there
// does not block the next command, which waits in finish only if the output
// register is still valid and stalled when it gets there.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_find (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           mode,
	input  logic [plist_pkg::POS_W-1:0]          position,
	input  logic signed [plist_pkg::VAL_W-1:0]   value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic signed [plist_pkg::VAL_W-1:0]   removed_value,
	output logic [plist_pkg::POS_W-1:0]          found_position,
	output logic [plist_pkg::OUT_CNT_W-1:0]      entry_count
);
	import plist_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;

	// Command word held from accept until finish
	mode_t                   mode_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] value_q;

	// Execute results
	status_t                 status_q;
	logic signed [VAL_W-1:0] removed_q;

	// Output register
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic signed [VAL_W-1:0] out_removed_q;
	logic [POS_W-1:0]        out_found_q;
	logic [OUT_CNT_W-1:0]    out_count_q;

	cell_ctl_t               ctl;
	logic signed [VAL_W-1:0] entries [LIST_DEPTH];
	logic signed [VAL_W-1:0] sel_entries [LIST_DEPTH];
	logic [LIST_DEPTH-1:0]   hit_flags;
	logic signed [VAL_W-1:0] sel_or;

	logic                    accept;
	logic                    exec;
	logic                    out_free;
	logic [CMP_W-1:0]        pos_ext;
	logic [CMP_W-1:0]        cnt_ext;
	logic                    ins_pos_ok;
	logic                    del_pos_ok;
	logic                    full;
	status_t                 status_nx;
	logic [POS_W-1:0]        found_pos;
	logic                    any_match;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign exec     = (state_q == ST_EXEC);
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------- checks
	assign pos_ext    = CMP_W'(pos_q);
	assign cnt_ext    = CMP_W'(count_q);
	assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
	assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
	assign full       = (count_q == CNT_W'(LIST_DEPTH));

	always_comb begin
		status_nx = STAT_OK;
		case (mode_q)
			MODE_INSERT: begin
				if (!ins_pos_ok) begin
					status_nx = STAT_BAD_POS;
				end else if (full) begin
					status_nx = STAT_FULL;
				end
			end
			MODE_DELETE: begin
				if (!del_pos_ok) begin
					status_nx = STAT_BAD_POS;
				end
			end
			default: begin
				status_nx = STAT_OK;  // find is resolved in finish; clear never fails
			end
		endcase
	end

	// Broadcast to the chain only during execute; insert and delete only for a legal change
	always_comb begin
		ctl.ins = exec && (mode_q == MODE_INSERT) && ins_pos_ok && !full;
		ctl.del = exec && (mode_q == MODE_DELETE) && del_pos_ok;
		ctl.cap = exec;
	end

	// ---------------------------------------------------------------- chain
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_in;
		logic signed [VAL_W-1:0] right_in;

		if (i == 0) begin : g_head
			assign left_in = value_q;
		end else begin : g_body
			assign left_in = entries[i-1];
		end

		// Tail takes its own entry on delete; it falls outside the count anyway
		if (i == LIST_DEPTH - 1) begin : g_tail
			assign right_in = entries[i];
		end else begin : g_link
			assign right_in = entries[i+1];
		end

		plist_cell u_cell (
			.clk         (clk),
			.idx         (IDX_W'(i)),
			.ctl         (ctl),
			.pos         (pos_q),
			.value       (value_q),
			.count       (count_q),
			.left_entry  (left_in),
			.right_entry (right_in),
			.entry       (entries[i]),
			.sel_entry   (sel_entries[i]),
			.match       (hit_flags[i])
		);
	end

	// At most one slot drives a nonzero selected entry
	always_comb begin
		sel_or = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			sel_or = sel_or | sel_entries[i];
		end
	end

	// First hit wins: scan from the top so the lowest slot overrides
	always_comb begin
		found_pos = '0;
		for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
			if (hit_flags[i]) begin
				found_pos = POS_W'(i + 1);
			end
		end
	end

	assign any_match = |hit_flags;

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					if (ctl.ins) begin
						count_q <= count_q + CNT_W'(1);
					end else if (ctl.del) begin
						count_q <= count_q - CNT_W'(1);
					end else if (mode_q == MODE_CLEAR) begin
						count_q <= '0;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Load on finish, drop once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode_t'(mode);
			pos_q   <= position;
			value_q <= value;
		end
		if (exec) begin
			status_q  <= status_nx;
			removed_q <= ctl.del ? sel_or : '0;
		end
		if (state_q == ST_FIN && out_free) begin
			out_removed_q <= removed_q;
			out_count_q   <= cnt_to_out(count_q);
			if (mode_q == MODE_FIND) begin
				out_status_q <= any_match ? STAT_OK : STAT_NO_MATCH;
				out_found_q  <= any_match ? found_pos : '0;
			end else begin
				out_status_q <= status_q;
				out_found_q  <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign removed_value  = out_removed_q;
	assign found_position = out_found_q;
	assign entry_count    = out_count_q;

	// ---------------------------------------------------------------- assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_DEPTH))
		else $error("list count exceeds depth");

	a_count_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_EXEC |=> $stable(count_q))
		else $error("list count changed outside execute");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result appeared without a finish step");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_found_q != '0) |->
			(out_status_q == STAT_OK && CMP_W'(out_found_q) <= CMP_W'(out_count_q)))
		else $error("found position beyond entry count");

	a_one_change: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.ins && ctl.del))
		else $error("insert and delete driven together");

endmodule

// File: tb/sv/tb_positional_list_insert_delete_find.sv
// ----------------------------------------------------------------------------
// tb_positional_list_insert_delete_find
// Self-checking bench for the positional list block. Directed words hit the
// empty list, a full list, bad positions, first-match search and clear; a
// long random mix then fills and drains the list with random idling on both
// channels. A shadow list in the bench predicts every result word.
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete_find;
	timeunit 1ns;
	timeprecision 1ps;

	import plist_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 1300;
	localparam int STEADY_WORDS   = 150;
	localparam int EPOCH_WORDS    = 120;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// One predicted result word
	typedef struct {
		status_t                    status;
		logic signed [VAL_W-1:0]    removed;
		logic [POS_W-1:0]           found;
		logic [OUT_CNT_W-1:0]       count;
	} list_reply_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [1:0]                   mode;
	logic [POS_W-1:0]             position;
	logic signed [VAL_W-1:0]      value;
	logic                         out_valid;
	logic                         out_stall;
	logic [1:0]                   status;
	logic signed [VAL_W-1:0]      removed_value;
	logic [POS_W-1:0]             found_position;
	logic [OUT_CNT_W-1:0]         entry_count;

	// Shadow copy of the list contents and its length
	logic signed [VAL_W-1:0] shadow_entries [LIST_DEPTH];
	int                      shadow_len;

	list_reply_t pending_replies [$];

	int errors;
	int words_sent;
	int replies_checked;
	int op_seen [4];
	int status_seen [4];
	int idle_cycles;
	bit steady;

	positional_list_insert_delete_find i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.position       (position),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.removed_value  (removed_value),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one operation to the shadow list and return the word it yields.
	// Failing operations leave the list as it was.
	function automatic list_reply_t apply_list_op(input mode_t op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		list_reply_t r;
		int          p;
		r.status  = STAT_OK;
		r.removed = '0;
		r.found   = '0;
		p = int'(pos);
		case (op)
			MODE_INSERT: begin
				// position check wins over the full check
				if (p < 1 || p > shadow_len + 1) begin
					r.status = STAT_BAD_POS;
				end else if (shadow_len >= LIST_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					for (int i = shadow_len; i >= p; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[p-1] = val;
					shadow_len++;
				end
			end
			MODE_DELETE: begin
				if (p < 1 || p > shadow_len) begin
					r.status = STAT_BAD_POS;
				end else begin
					r.removed = shadow_entries[p-1];
					for (int i = p; i < shadow_len; i++)
						shadow_entries[i-1] = shadow_entries[i];
					shadow_len--;
				end
			end
			MODE_FIND: begin
				r.status = STAT_NO_MATCH;
				for (int i = 0; i < shadow_len; i++) begin
					if (shadow_entries[i] == val) begin
						r.status = STAT_OK;
						r.found  = POS_W'(i + 1);
						break;
					end
				end
			end
			default: begin
				shadow_len = 0;
			end
		endcase
		r.count = OUT_CNT_W'(shadow_len);
		return r;
	endfunction

	// Mix of small values (duplicates likely), in-range values and raw 31-bit patterns
	function automatic logic signed [VAL_W-1:0] random_value();
		int          v;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			v = int'($urandom_range(0, 20)) - 10;
		end else if (pick < 7) begin
			v = int'($urandom_range(0, 1999999998)) - 999999999;
		end else begin
			v = int'($urandom);
		end
		return VAL_W'(v);
	endfunction

	// Send one word: maybe idle first, then hold it until the block takes it,
	// then record the predicted result. in_valid stays high on return.
	task automatic send_word(input mode_t op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		list_reply_t r;
		if (!steady && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		position <= pos;
		value    <= val;
		do @(posedge clk); while (in_stall);
		r = apply_list_op(op, pos, val);
		pending_replies.insert(pending_replies.size(), r);
		op_seen[op]++;
		status_seen[r.status]++;
		words_sent++;
	endtask

	// Operations on an empty list all fail; position zero is never valid
	task automatic test_empty_list_ops();
		send_word(MODE_INSERT, 5'd0, '0);
		send_word(MODE_DELETE, 5'd1, VAL_MAX);
		send_word(MODE_FIND, 5'd0, '0);
	endtask

	// Build up to a full list with front, middle and tail inserts, then hit
	// the full case and the bad-position case on a full list
	task automatic test_fill_to_full();
		send_word(MODE_INSERT, 5'd1, VAL_MAX);
		send_word(MODE_INSERT, 5'd1, VAL_MIN);
		send_word(MODE_INSERT, 5'd2, '0);
		for (int k = 1; k <= 12; k++)
			send_word(MODE_INSERT, POS_W'(shadow_len + 1), VAL_W'(-k * 77777));
		// duplicate of an earlier entry at the tail
		send_word(MODE_INSERT, 5'd16, VAL_MAX);
		send_word(MODE_INSERT, 5'd8, 31'sd42);
		send_word(MODE_INSERT, 5'd31, 31'sd42);
	endtask

	// Find must return the first of two equal entries; a miss gives zero
	task automatic test_find_first_match();
		send_word(MODE_FIND, 5'd31, VAL_MAX);
		send_word(MODE_FIND, 5'd0, 31'sd12345);
	endtask

	// Delete at position zero, at the tail and at the head
	task automatic test_delete_positions();
		send_word(MODE_DELETE, 5'd0, '0);
		send_word(MODE_DELETE, POS_W'(shadow_len), '0);
		send_word(MODE_DELETE, 5'd1, VAL_MIN);
	endtask

	// Clear ignores position and value
	task automatic test_clear_list();
		send_word(MODE_CLEAR, 5'd31, VAL_MIN);
	endtask

	// Random mix: alternate fill-biased and drain-biased epochs so the list
	// swings between empty and full; most positions are legal, some are noise
	task automatic test_random_mix(input int n_words);
		mode_t                   op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		int unsigned             roll;
		bit                      filling;
		for (int k = 0; k < n_words; k++) begin
			filling = ((k / EPOCH_WORDS) % 2) == 0;
			roll = $urandom_range(0, 99);
			pos  = POS_W'($urandom_range(0, 31));
			val  = random_value();
			if (!filling && roll < 2) begin
				op = MODE_CLEAR;
			end else if (roll < 30) begin
				op = MODE_FIND;
				// mostly search for something that is held
				if (shadow_len > 0 && $urandom_range(0, 3) != 0)
					val = shadow_entries[$urandom_range(0, shadow_len - 1)];
			end else if (roll < (filling ? 80 : 50)) begin
				op = MODE_INSERT;
				if ($urandom_range(0, 99) < 85)
					pos = POS_W'($urandom_range(1, shadow_len + 1));
			end else begin
				op = MODE_DELETE;
				if (shadow_len > 0 && $urandom_range(0, 99) < 85)
					pos = POS_W'($urandom_range(1, shadow_len));
			end
			send_word(op, pos, val);
		end
	endtask

	// Receiver: stall the result channel in random bursts, none once steady
	always begin
		@(posedge clk);
		if (!steady && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	// Check each accepted result word against the oldest prediction
	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$error("result word with no prediction pending");
				errors++;
			end else begin
				want = pending_replies.pop_front();
				replies_checked++;
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (removed_value !== want.removed) begin
					$error("removed_value: expected %0d, got %0d",
						want.removed, removed_value);
					errors++;
				end
				if (found_position !== want.found) begin
					$error("found_position: expected %0d, got %0d",
						want.found, found_position);
					errors++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d",
						want.count, entry_count);
					errors++;
				end
			end
		end
	end

	// Watchdog: drop the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_positional_list_insert_delete_find: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		errors          = 0;
		words_sent      = 0;
		replies_checked = 0;
		steady          = 1'b0;
		shadow_len      = 0;
		for (int i = 0; i < LIST_DEPTH; i++)
			shadow_entries[i] = '0;
		for (int i = 0; i < 4; i++) begin
			op_seen[i]     = 0;
			status_seen[i] = 0;
		end
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		mode      <= MODE_INSERT;
		position  <= '0;
		value     <= '0;
		out_stall <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list_ops();
		test_fill_to_full();
		test_find_first_match();
		test_delete_positions();
		test_clear_list();
		test_random_mix(RANDOM_WORDS);
		// last stretch: back-to-back words, no stalls
		steady = 1'b1;
		test_random_mix(STEADY_WORDS);
		in_valid <= 1'b0;

		// drain outstanding results, then give the pipeline time to misbehave
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d words (%0d insert, %0d delete, %0d find, %0d clear),",
			words_sent, op_seen[MODE_INSERT], op_seen[MODE_DELETE], op_seen[MODE_FIND],
			op_seen[MODE_CLEAR]);
		$display("%0d results checked; outcomes: %0d ok, %0d bad position, %0d full list, %0d no match",
			replies_checked, status_seen[STAT_OK], status_seen[STAT_BAD_POS],
			status_seen[STAT_FULL], status_seen[STAT_NO_MATCH]);
		if (errors == 0) begin
			$display("tb_positional_list_insert_delete_find: done, clean");
		end else begin
			$display("tb_positional_list_insert_delete_find: done, errors");
		end
		$finish;
	end

endmodule
